// ===== rtl/core/subtitle_segment_clut_decoder_macros.svh =====
// Assertion macros for the subtitle segment colour table decoder
`ifndef SUBTITLE_SEGMENT_CLUT_DECODER_MACROS_SVH
`define SUBTITLE_SEGMENT_CLUT_DECODER_MACROS_SVH

`ifndef SYNTH
`define SSCD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sscd assertion failed");
`define SSCD_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("sscd forbidden condition seen");
`else
`define SSCD_ASSERT(lbl, clk, rst_n, prop)
`define SSCD_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== rtl/core/sscd_pkg.sv =====
// Shared types and constants of the subtitle segment colour table decoder
`timescale 1ns / 1ps
`default_nettype none

package sscd_pkg;

    localparam int PALETTE_SLOTS = 256;
    localparam int COUNT_W       = $clog2(PALETTE_SLOTS + 1);

    localparam logic [7:0] SYNC_BYTE     = 8'h0F;
    localparam logic [7:0] CLUT_TYPE_RST = 8'd18;
    localparam logic [7:0] SLOT_LAST     = 8'(PALETTE_SLOTS - 1);

    localparam logic RK_ENTRY = 1'b0;
    localparam logic RK_END   = 1'b1;

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_TYPE,
        PH_PAGE_HI,
        PH_PAGE_LO,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SKIP,
        PH_TAB_ID,
        PH_TAB_VER,
        PH_ENT_ID,
        PH_ENT_FLAGS,
        PH_D0,
        PH_D1,
        PH_D2,
        PH_D3,
        PH_END
    } t_phase;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] table_id;
        logic [3:0] table_version;
        logic [7:0] palette_index;
        logic [7:0] entry_slot;
        logic [7:0] luma;
        logic [7:0] chroma_red;
        logic [7:0] chroma_blue;
        logic [7:0] opacity;
        logic       full_range;
        logic       segment_ok;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/subtitle_segment_clut_decoder.sv =====
// Top level of the subtitle segment colour table decoder
// Usage:
//   Request channel: i_in_valid / o_in_ready carry one stream byte
//   (i_data_byte) and a restart flag per request. Restart drops any partial
//   segment and hunts for the sync byte before that byte is parsed.
//   Result channel: o_out_valid / i_out_ready carry palette entries and the
//   end-of-table result with its length status.
//   Configuration: i_cfg_wr_en writes i_cfg_wr_data into the table segment
//   type code at the clock edge; write it only while the decoder is idle.
// Timing:
//   One byte is taken every clock while o_in_ready is high. A result caused
//   by a byte is registered in the result register, or in the skid stage if
//   that is full; the end-of-table result is raised by the byte that follows
//   the last segment byte. The result register plus one skid stage decouple
//   the channels, so o_in_ready falls only while both hold a result the receiver has not taken.
// Reset:
//   Synchronous, active low: type code returns to 18, the parser hunts for
//   sync, and both result stages are emptied.
`timescale 1ns / 1ps
`default_nettype none

module subtitle_segment_clut_decoder
    import sscd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    input  wire logic        i_in_valid,
    output      logic        o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_restart,
    output      logic        o_out_valid,
    input  wire logic        i_out_ready,
    output      logic        o_result_kind,
    output      logic [7:0]  o_table_id,
    output      logic [3:0]  o_table_version,
    output      logic [7:0]  o_palette_index,
    output      logic [7:0]  o_entry_slot,
    output      logic [7:0]  o_luma,
    output      logic [7:0]  o_chroma_red,
    output      logic [7:0]  o_chroma_blue,
    output      logic [7:0]  o_opacity,
    output      logic        o_full_range,
    output      logic        o_segment_ok
);

    logic [7:0] r_clut_type_code;
    logic       accept;
    logic       res_valid;
    t_result    res;
    t_result    out_data;

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clut_type_code <= CLUT_TYPE_RST;
        end else if (i_cfg_wr_en) begin
            r_clut_type_code <= i_cfg_wr_data;
        end
    end

    sscd_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_data_byte      (i_data_byte),
        .i_restart        (i_restart),
        .i_clut_type_code (r_clut_type_code),
        .o_res_valid      (res_valid),
        .o_res            (res)
    );

    sscd_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (accept && res_valid),
        .i_push_data  (res),
        .o_push_ready (o_in_ready),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_data       (out_data)
    );

    assign o_result_kind   = out_data.result_kind;
    assign o_table_id      = out_data.table_id;
    assign o_table_version = out_data.table_version;
    assign o_palette_index = out_data.palette_index;
    assign o_entry_slot    = out_data.entry_slot;
    assign o_luma          = out_data.luma;
    assign o_chroma_red    = out_data.chroma_red;
    assign o_chroma_blue   = out_data.chroma_blue;
    assign o_opacity       = out_data.opacity;
    assign o_full_range    = out_data.full_range;
    assign o_segment_ok    = out_data.segment_ok;

endmodule

`default_nettype wire

// ===== rtl/core/sscd_parser.sv =====
// Byte parser: segment header, table header and palette entry decode
`timescale 1ns / 1ps
`default_nettype none

module sscd_parser
    import sscd_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_accept,
    input  wire logic [7:0]   i_data_byte,
    input  wire logic         i_restart,
    input  wire logic [7:0]   i_clut_type_code,
    output      logic         o_res_valid,
    output      t_result      o_res
);

    t_phase               r_phase,        n_phase;
    logic [7:0]           r_seg_kind,     n_seg_kind;
    logic [15:0]          r_bytes_left,   n_bytes_left;
    logic [7:0]           r_table,        n_table;
    logic [3:0]           r_version,      n_version;
    logic [7:0]           r_entry,        n_entry;
    logic                 r_entry_full,   n_entry_full;
    logic [23:0]          r_entry_bytes,  n_entry_bytes;
    logic [COUNT_W-1:0]   r_entry_count,  n_entry_count;
    logic                 r_length_error, n_length_error;

    t_phase      ph_eff;
    logic [31:0] word;
    logic        emit;
    logic [15:0] left_dec;
    logic [15:0] seg_len;

    always_comb begin
        ph_eff   = (r_phase == PH_END || i_restart) ? PH_HUNT : r_phase;
        word     = {r_entry_bytes, i_data_byte};
        emit     = (ph_eff == PH_D1 && !r_entry_full) || ph_eff == PH_D3;
        left_dec = r_bytes_left - 16'(r_bytes_left != 16'd0);
        seg_len  = {r_bytes_left[15:8], i_data_byte};
    end

    always_comb begin
        t_phase body_next;
        body_next      = PH_ENT_ID;
        n_phase        = ph_eff;
        n_seg_kind     = r_seg_kind;
        n_bytes_left   = r_bytes_left;
        n_table        = r_table;
        n_version      = r_version;
        n_entry        = r_entry;
        n_entry_full   = r_entry_full;
        n_entry_bytes  = r_entry_bytes;
        n_entry_count  = r_entry_count;
        n_length_error = r_length_error;
        case (ph_eff)
            PH_HUNT: begin
                n_phase = (i_data_byte == SYNC_BYTE) ? PH_TYPE : PH_HUNT;
            end
            PH_TYPE: begin
                n_seg_kind = i_data_byte;
                n_phase    = PH_PAGE_HI;
            end
            PH_PAGE_HI: n_phase = PH_PAGE_LO;
            PH_PAGE_LO: n_phase = PH_LEN_HI;
            PH_LEN_HI: begin
                n_bytes_left = {i_data_byte, 8'h00};
                n_phase      = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_bytes_left = seg_len;
                if (r_seg_kind == i_clut_type_code) begin
                    n_table        = '0;
                    n_version      = '0;
                    n_entry        = '0;
                    n_entry_full   = 1'b0;
                    n_entry_bytes  = '0;
                    n_entry_count  = '0;
                    n_length_error = 1'b0;
                    if (seg_len == 16'd0) begin
                        n_length_error = 1'b1;
                        n_phase        = PH_END;
                    end else begin
                        n_phase = PH_TAB_ID;
                    end
                end else begin
                    n_phase = (seg_len == 16'd0) ? PH_HUNT : PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_bytes_left = left_dec;
                if (left_dec == 16'd0) begin
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                n_bytes_left = left_dec;
                case (ph_eff)
                    PH_TAB_ID: begin
                        n_table   = i_data_byte;
                        body_next = PH_TAB_VER;
                    end
                    PH_TAB_VER: begin
                        n_version = i_data_byte[7:4];
                        body_next = PH_ENT_ID;
                    end
                    PH_ENT_ID: begin
                        n_entry   = i_data_byte;
                        body_next = PH_ENT_FLAGS;
                    end
                    PH_ENT_FLAGS: begin
                        n_entry_full  = i_data_byte[0];
                        n_entry_bytes = '0;
                        body_next     = PH_D0;
                    end
                    PH_D0: begin
                        n_entry_bytes = {16'h0000, i_data_byte};
                        body_next     = PH_D1;
                    end
                    PH_D1: begin
                        n_entry_bytes = word[23:0];
                        body_next     = r_entry_full ? PH_D2 : PH_ENT_ID;
                    end
                    PH_D2: begin
                        n_entry_bytes = word[23:0];
                        body_next     = PH_D3;
                    end
                    default: begin
                        n_entry_bytes = word[23:0];
                        body_next     = PH_ENT_ID;
                    end
                endcase
                if (emit) begin
                    if (r_entry_count >= COUNT_W'(PALETTE_SLOTS)) begin
                        n_length_error = 1'b1;
                    end else begin
                        n_entry_count = r_entry_count + COUNT_W'(1);
                    end
                end
                if (left_dec == 16'd0) begin
                    if (body_next != PH_ENT_ID) begin
                        n_length_error = 1'b1;
                    end
                    n_phase = PH_END;
                end else begin
                    n_phase = body_next;
                end
            end
        endcase
    end

    always_comb begin
        logic [7:0] y, cr, cb, t;
        if (r_entry_full) begin
            y  = word[31:24];
            cr = word[23:16];
            cb = word[15:8];
            t  = word[7:0];
        end else begin
            y  = {word[15:10], 2'b00};
            cr = {word[9:6], 4'h0};
            cb = {word[5:2], 4'h0};
            t  = {word[1:0], 6'h00};
        end
        o_res_valid         = 1'b0;
        o_res               = '0;
        o_res.table_id      = r_table;
        o_res.table_version = r_version;
        if (r_phase == PH_END) begin
            o_res_valid       = 1'b1;
            o_res.result_kind = RK_END;
            o_res.entry_slot  = (int'(r_entry_count) > 255) ? 8'hFF : 8'(r_entry_count);
            o_res.segment_ok  = !r_length_error;
        end else if (emit) begin
            o_res_valid         = 1'b1;
            o_res.result_kind   = RK_ENTRY;
            o_res.palette_index = r_entry;
            o_res.entry_slot    = (r_entry_count >= COUNT_W'(PALETTE_SLOTS)) ?
                                  SLOT_LAST : 8'(r_entry_count);
            o_res.luma          = y;
            o_res.chroma_red    = (y == 8'h00) ? 8'h00 : cr;
            o_res.chroma_blue   = (y == 8'h00) ? 8'h00 : cb;
            o_res.opacity       = (y == 8'h00) ? 8'h00 : ~t;
            o_res.full_range    = r_entry_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_seg_kind     <= '0;
            r_bytes_left   <= '0;
            r_table        <= '0;
            r_version      <= '0;
            r_entry        <= '0;
            r_entry_full   <= 1'b0;
            r_entry_bytes  <= '0;
            r_entry_count  <= '0;
            r_length_error <= 1'b0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_seg_kind     <= n_seg_kind;
            r_bytes_left   <= n_bytes_left;
            r_table        <= n_table;
            r_version      <= n_version;
            r_entry        <= n_entry;
            r_entry_full   <= n_entry_full;
            r_entry_bytes  <= n_entry_bytes;
            r_entry_count  <= n_entry_count;
            r_length_error <= n_length_error;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sscd_out_buf.sv =====
// Result register with skid stage between parser and result channel
`timescale 1ns / 1ps
`default_nettype none

`include "subtitle_segment_clut_decoder_macros.svh"

module sscd_out_buf
    import sscd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_result  i_push_data,
    output      logic     o_push_ready,
    output      logic     o_valid,
    input  wire logic     i_ready,
    output      t_result  o_data
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop          = r_main_valid && i_ready;
    assign o_push_ready = !r_skid_valid;
    assign o_valid      = r_main_valid;
    assign o_data       = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_main <= r_skid_valid ? r_skid : i_push_data;
        end else if (i_push && !r_main_valid) begin
            r_main <= i_push_data;
        end
        if (i_push && r_main_valid && !pop) begin
            r_skid <= i_push_data;
        end
    end

    `SSCD_NEVER(a_skid_without_main, i_clk, i_rst_n, r_skid_valid && !r_main_valid)
    `SSCD_ASSERT(a_stall_fills_skid, i_clk, i_rst_n, i_push && r_main_valid && !i_ready |=> r_skid_valid)
    `SSCD_ASSERT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && i_ready |=> r_main_valid && !r_skid_valid)

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the subtitle segment colour table decoder
`timescale 1ns / 1ps

module tb_top
    import sscd_pkg::*;
();

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'h00;
    logic       i_in_valid    = 1'b0;
    logic [7:0] i_data_byte   = 8'h00;
    logic       i_restart     = 1'b0;
    logic       i_out_ready   = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_result_kind;
    logic [7:0] o_table_id;
    logic [3:0] o_table_version;
    logic [7:0] o_palette_index;
    logic [7:0] o_entry_slot;
    logic [7:0] o_luma;
    logic [7:0] o_chroma_red;
    logic [7:0] o_chroma_blue;
    logic [7:0] o_opacity;
    logic       o_full_range;
    logic       o_segment_ok;

    subtitle_segment_clut_decoder DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_restart       (i_restart),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_kind   (o_result_kind),
        .o_table_id      (o_table_id),
        .o_table_version (o_table_version),
        .o_palette_index (o_palette_index),
        .o_entry_slot    (o_entry_slot),
        .o_luma          (o_luma),
        .o_chroma_red    (o_chroma_red),
        .o_chroma_blue   (o_chroma_blue),
        .o_opacity       (o_opacity),
        .o_full_range    (o_full_range),
        .o_segment_ok    (o_segment_ok)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // parser state as seen from the stream
    logic [7:0]  type_code    = CLUT_TYPE_RST;
    t_phase      ph           = PH_HUNT;
    logic [7:0]  seg_kind     = 8'h00;
    logic [15:0] bytes_left   = 16'h0000;
    logic [7:0]  cur_table    = 8'h00;
    logic [3:0]  cur_version  = 4'h0;
    logic [7:0]  cur_entry    = 8'h00;
    logic        entry_full   = 1'b0;
    logic [31:0] entry_data   = 32'h0;
    logic [8:0]  entry_count  = 9'd0;
    logic        length_error = 1'b0;

    t_result     palette_result_q[$];
    logic [7:0]  stream_q[$];
    logic [7:0]  seg_body[$];

    int          mismatch_count = 0;
    int          items_sent     = 0;
    bit          idling         = 1'b1;
    int          stall_left     = 0;

    task automatic emit_palette_entry();
        logic [7:0] y;
        logic [7:0] cr;
        logic [7:0] cb;
        logic [7:0] t;
        t_result    r;
        if (entry_full) begin
            {y, cr, cb, t} = entry_data;
        end else begin
            y  = {entry_data[15:10], 2'b00};
            cr = {entry_data[9:6], 4'h0};
            cb = {entry_data[5:2], 4'h0};
            t  = {entry_data[1:0], 6'h00};
        end
        t = 8'hFF - t;
        if (y == 8'h00) begin
            cr = 8'h00;
            cb = 8'h00;
            t  = 8'h00;
        end
        r               = '0;
        r.result_kind   = RK_ENTRY;
        r.table_id      = cur_table;
        r.table_version = cur_version;
        r.palette_index = cur_entry;
        r.luma          = y;
        r.chroma_red    = cr;
        r.chroma_blue   = cb;
        r.opacity       = t;
        r.full_range    = entry_full;
        if (entry_count >= PALETTE_SLOTS) begin
            length_error = 1'b1;
            r.entry_slot = SLOT_LAST;
        end else begin
            r.entry_slot = entry_count[7:0];
            entry_count  = entry_count + 9'd1;
        end
        palette_result_q.push_back(r);
    endtask

    task automatic parse_stream_byte(input logic [7:0] b, input logic rs);
        t_result r;
        if (ph == PH_END) begin
            r               = '0;
            r.result_kind   = RK_END;
            r.table_id      = cur_table;
            r.table_version = cur_version;
            r.entry_slot    = (entry_count > 9'd255) ? 8'hFF : entry_count[7:0];
            r.segment_ok    = !length_error;
            palette_result_q.push_back(r);
            ph = PH_HUNT;
        end
        if (rs)
            ph = PH_HUNT;
        case (ph)
            PH_HUNT: begin
                if (b == SYNC_BYTE)
                    ph = PH_TYPE;
            end
            PH_TYPE: begin
                seg_kind = b;
                ph = PH_PAGE_HI;
            end
            PH_PAGE_HI: ph = PH_PAGE_LO;
            PH_PAGE_LO: ph = PH_LEN_HI;
            PH_LEN_HI: begin
                bytes_left = {b, 8'h00};
                ph = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                bytes_left[7:0] = b;
                if (seg_kind == type_code) begin
                    cur_table    = 8'h00;
                    cur_version  = 4'h0;
                    cur_entry    = 8'h00;
                    entry_full   = 1'b0;
                    entry_data   = 32'h0;
                    entry_count  = 9'd0;
                    length_error = 1'b0;
                    if (bytes_left == 16'h0000) begin
                        length_error = 1'b1;
                        ph = PH_END;
                    end else begin
                        ph = PH_TAB_ID;
                    end
                end else begin
                    ph = (bytes_left == 16'h0000) ? PH_HUNT : PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (bytes_left != 16'h0000)
                    bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'h0000)
                    ph = PH_HUNT;
            end
            default: begin
                if (bytes_left != 16'h0000)
                    bytes_left = bytes_left - 16'd1;
                case (ph)
                    PH_TAB_ID: begin
                        cur_table = b;
                        ph = PH_TAB_VER;
                    end
                    PH_TAB_VER: begin
                        cur_version = b[7:4];
                        ph = PH_ENT_ID;
                    end
                    PH_ENT_ID: begin
                        cur_entry = b;
                        ph = PH_ENT_FLAGS;
                    end
                    PH_ENT_FLAGS: begin
                        entry_full = b[0];
                        entry_data = 32'h0;
                        ph = PH_D0;
                    end
                    PH_D0: begin
                        entry_data = {24'h0, b};
                        ph = PH_D1;
                    end
                    PH_D1: begin
                        entry_data = {entry_data[23:0], b};
                        if (entry_full) begin
                            ph = PH_D2;
                        end else begin
                            emit_palette_entry();
                            ph = PH_ENT_ID;
                        end
                    end
                    PH_D2: begin
                        entry_data = {entry_data[23:0], b};
                        ph = PH_D3;
                    end
                    default: begin
                        entry_data = {entry_data[23:0], b};
                        emit_palette_entry();
                        ph = PH_ENT_ID;
                    end
                endcase
                if (bytes_left == 16'h0000) begin
                    if (ph != PH_ENT_ID)
                        length_error = 1'b1;
                    ph = PH_END;
                end
            end
        endcase
    endtask

    function automatic string show(input t_result r);
        return $sformatf({"kind=%0d table=%02h ver=%0h id=%02h slot=%0d y=%02h cr=%02h",
                          " cb=%02h op=%02h full=%0d ok=%0d"},
                         r.result_kind, r.table_id, r.table_version, r.palette_index,
                         r.entry_slot, r.luma, r.chroma_red, r.chroma_blue, r.opacity,
                         r.full_range, r.segment_ok);
    endfunction

    function automatic string field_diff(input t_result w, input t_result g);
        string s;
        s = "";
        if (w.result_kind   !== g.result_kind)   s = {s, " result_kind"};
        if (w.table_id      !== g.table_id)      s = {s, " table_id"};
        if (w.table_version !== g.table_version) s = {s, " table_version"};
        if (w.palette_index !== g.palette_index) s = {s, " palette_index"};
        if (w.entry_slot    !== g.entry_slot)    s = {s, " entry_slot"};
        if (w.luma          !== g.luma)          s = {s, " luma"};
        if (w.chroma_red    !== g.chroma_red)    s = {s, " chroma_red"};
        if (w.chroma_blue   !== g.chroma_blue)   s = {s, " chroma_blue"};
        if (w.opacity       !== g.opacity)       s = {s, " opacity"};
        if (w.full_range    !== g.full_range)    s = {s, " full_range"};
        if (w.segment_ok    !== g.segment_ok)    s = {s, " segment_ok"};
        return s;
    endfunction

    task automatic note_mismatch(input string what, input t_result want, input t_result got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t %s: expected %s, actual %s", $realtime, what, show(want), show(got));
    endtask

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        string   bad;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_result_kind, o_table_id, o_table_version, o_palette_index,
                   o_entry_slot, o_luma, o_chroma_red, o_chroma_blue, o_opacity,
                   o_full_range, o_segment_ok};
            if (palette_result_q.size() == 0) begin
                note_mismatch("unexpected result", '0, got);
            end else begin
                want = palette_result_q.pop_front();
                bad  = field_diff(want, got);
                if (bad != "")
                    note_mismatch({"mismatch in", bad}, want, got);
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idling && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_request(input logic [7:0] b, input logic rs);
        int gap;
        gap = 0;
        if (idling && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 4);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_restart   <= rs;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        parse_stream_byte(b, rs);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_stream(input int restart_pct);
        logic [7:0] b;
        while (stream_q.size() != 0) begin
            b = stream_q.pop_front();
            send_request(b, $urandom_range(0, 99) < restart_pct);
        end
    endtask

    task automatic wait_for_results();
        while (palette_result_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_type_code(input logic [7:0] code);
        i_in_valid <= 1'b0;
        wait_for_results();
        repeat (4) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= code;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        type_code = code;
    endtask

    task automatic add_header(input logic [7:0] kind, input logic [15:0] len);
        stream_q.push_back(SYNC_BYTE);
        stream_q.push_back(kind);
        stream_q.push_back(8'($urandom_range(0, 255)));
        stream_q.push_back(8'($urandom_range(0, 255)));
        stream_q.push_back(len[15:8]);
        stream_q.push_back(len[7:0]);
    endtask

    task automatic add_entry(input bit full, input bit dark);
        logic [7:0]  flags;
        logic [15:0] w;
        seg_body.push_back(8'($urandom_range(0, 255)));
        flags    = 8'($urandom_range(0, 255));
        flags[0] = full;
        seg_body.push_back(flags);
        if (full) begin
            seg_body.push_back(dark ? 8'h00 : 8'($urandom_range(0, 255)));
            repeat (3) seg_body.push_back(8'($urandom_range(0, 255)));
        end else begin
            w = 16'($urandom_range(0, 65535));
            if (dark)
                w[15:10] = 6'h00;
            seg_body.push_back(w[15:8]);
            seg_body.push_back(w[7:0]);
        end
    endtask

    // length is the true body length plus delta, so a negative delta truncates
    task automatic add_clut_segment(input int n_ent, input int delta, input int full_pct);
        int len;
        int i;
        seg_body.delete();
        seg_body.push_back(8'($urandom_range(0, 255)));
        seg_body.push_back(8'($urandom_range(0, 255)));
        for (i = 0; i < n_ent; i++)
            add_entry($urandom_range(0, 99) < full_pct, $urandom_range(0, 7) == 0);
        len = seg_body.size() + delta;
        if (len < 0)
            len = 0;
        add_header(type_code, 16'(len));
        for (i = 0; i < len; i++) begin
            if (i < seg_body.size())
                stream_q.push_back(seg_body[i]);
            else
                stream_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_entry_extremes();
        logic [7:0] pattern [0:22];
        pattern = '{SYNC_BYTE, type_code, 8'h00, 8'h00, 8'h00, 8'h10,
                    8'hFF, 8'hF0,
                    8'hFF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                    8'h00, 8'hFE, 8'hFF, 8'hFF,
                    8'h5A, 8'h00, 8'h00, 8'hFF,
                    8'h00};
        foreach (pattern[i])
            stream_q.push_back(pattern[i]);
        send_stream(0);
    endtask

    task automatic test_short_segments();
        logic [7:0] other;
        other = type_code + 8'd1;
        // empty table segment, its end result taken by a restart request
        add_header(type_code, 16'd0);
        send_stream(0);
        send_request(SYNC_BYTE, 1'b1);
        stream_q.push_back(other);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'h00);
        add_header(type_code, 16'd1);
        stream_q.push_back(8'h77);
        add_clut_segment(1, -1, 0);
        add_header(other, 16'd4);
        repeat (4) stream_q.push_back(SYNC_BYTE);
        add_header(type_code, 16'd10);
        stream_q.push_back(8'h31);
        stream_q.push_back(8'h20);
        stream_q.push_back(8'h08);
        send_stream(0);
        send_request(8'h00, 1'b1);
    endtask

    task automatic test_type_code();
        logic [7:0] codes [0:2];
        codes = '{8'h00, 8'hFF, 8'($urandom_range(0, 255))};
        foreach (codes[i]) begin
            write_type_code(codes[i]);
            add_clut_segment(2, 0, 50);
            add_header(codes[i] + 8'd1, 16'd2);
            stream_q.push_back(8'($urandom_range(0, 255)));
            stream_q.push_back(8'($urandom_range(0, 255)));
            add_header(CLUT_TYPE_RST, 16'd3);
            repeat (3) stream_q.push_back(8'($urandom_range(0, 255)));
            add_clut_segment(1, 0, 100);
            send_stream(0);
        end
    endtask

    task automatic test_overflow();
        add_clut_segment(PALETTE_SLOTS + 2, 0, 0);
        stream_q.push_back(8'h00);
        send_stream(0);
    endtask

    task automatic test_random_stream(input int n_items, input int restart_pct);
        int start;
        int pick;
        int delta;
        logic [7:0] other;
        start = items_sent;
        while (items_sent - start < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                case ($urandom_range(0, 9))
                    7:       delta = -$urandom_range(1, 3);
                    8:       delta = $urandom_range(1, 3);
                    9:       delta = -$urandom_range(1, 2);
                    default: delta = 0;
                endcase
                if (delta < 0 && $urandom_range(0, 1) == 0)
                    add_clut_segment(0, delta, 50);
                else
                    add_clut_segment($urandom_range(0, 6), delta, 50);
            end else if (pick < 75) begin
                other = 8'($urandom_range(0, 255));
                if (other == type_code)
                    other = other + 8'd1;
                delta = $urandom_range(0, 8);
                add_header(other, 16'(delta));
                repeat (delta) stream_q.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 5)) stream_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                add_clut_segment($urandom_range(8, 20), 0, 50);
            end
            send_stream(restart_pct);
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_entry_extremes();
        test_short_segments();
        test_type_code();
        test_overflow();
        test_random_stream(250, 2);
        write_type_code(CLUT_TYPE_RST);
        test_random_stream(150, 2);
        idling = 1'b0;
        test_random_stream(90, 1);
        i_in_valid <= 1'b0;
        wait_for_results();
        repeat (8) @(negedge i_clk);
        while (palette_result_q.size() != 0)
            note_mismatch("result never seen", palette_result_q.pop_front(), '0);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
